FILE: hw/rtl/bcu_pkg.sv
// Package for the binomial coefficient unit.
// Shared types between the sequencer and the divider; no dependencies.
`timescale 1ns / 1ps

package bcu_pkg;

  // Status returned by the iterative divider to the sequencer
  typedef struct packed {
    logic busy;  // a division is in progress
    logic done;  // one-cycle pulse: quotient is valid
  } bcu_div_status_t;

endpackage : bcu_pkg

FILE: hw/rtl/bcu_in_if.sv
// Input channel of the binomial coefficient unit: n and k with valid/ready.
// No dependencies.
`timescale 1ns / 1ps

interface bcu_in_if #(
  parameter int ARG_WIDTH = 6
);
  logic                 valid;
  logic                 ready;
  logic [ARG_WIDTH-1:0] n_value;
  logic [ARG_WIDTH-1:0] k_value;

  modport source (output valid, output n_value, output k_value, input ready);
  modport sink   (input valid, input n_value, input k_value, output ready);
endinterface : bcu_in_if

FILE: hw/rtl/bcu_out_if.sv
// Output channel of the binomial coefficient unit: coefficient and overflow flag.
// No dependencies.
`timescale 1ns / 1ps

interface bcu_out_if #(
  parameter int RESULT_WIDTH = 64
);
  logic                    valid;
  logic                    ready;
  logic [RESULT_WIDTH-1:0] coefficient;
  logic                    overflow;

  modport source (output valid, output coefficient, output overflow, input ready);
  modport sink   (input valid, input coefficient, input overflow, output ready);
endinterface : bcu_out_if

FILE: hw/rtl/bcu_mul.sv
// Shared multiplier of the binomial coefficient unit: running product times
// a small factor, with detection of a result wider than the running product.
`timescale 1ns / 1ps

module bcu_mul #(
  parameter int ARG_WIDTH    = 6,
  parameter int RESULT_WIDTH = 64
) (
  input  logic [RESULT_WIDTH-1:0] acc,
  input  logic [ARG_WIDTH-1:0]    factor,
  output logic [RESULT_WIDTH-1:0] product,
  output logic                    too_wide
);

  logic [RESULT_WIDTH+ARG_WIDTH-1:0] full;

  // Full-width product; any bit above the result width means overflow
  always_comb begin
    full     = {{ARG_WIDTH{1'b0}}, acc} * {{RESULT_WIDTH{1'b0}}, factor};
    product  = full[RESULT_WIDTH-1:0];
    too_wide = |full[RESULT_WIDTH+ARG_WIDTH-1:RESULT_WIDTH];
  end

endmodule : bcu_mul

FILE: hw/rtl/bcu_div.sv
// Restoring divider of the binomial coefficient unit, one quotient bit a cycle.
// Depends on bcu_pkg for the status struct.
`timescale 1ns / 1ps

module bcu_div
  import bcu_pkg::*;
#(
  parameter int RESULT_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [RESULT_WIDTH-1:0] dividend,
  input  logic [RESULT_WIDTH-1:0] divisor,
  output bcu_div_status_t         status,
  output logic [RESULT_WIDTH-1:0] quotient
);

  localparam int CntWidth = $clog2(RESULT_WIDTH + 1);

  logic [RESULT_WIDTH:0]   rem;
  logic [RESULT_WIDTH-1:0] quo;
  logic [RESULT_WIDTH-1:0] div_reg;
  logic [CntWidth-1:0]     count;
  logic                    busy;
  logic                    done;

  logic [RESULT_WIDTH:0]   rem_shift;
  logic [RESULT_WIDTH+1:0] diff;
  logic                    take;

  // One trial subtraction per cycle
  always_comb begin
    rem_shift = {rem[RESULT_WIDTH-1:0], quo[RESULT_WIDTH-1]};
    diff      = {1'b0, rem_shift} - {2'b00, div_reg};
    take      = ~diff[RESULT_WIDTH+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        rem     <= '0;
        quo     <= dividend;
        div_reg <= divisor;
        count   <= CntWidth'(RESULT_WIDTH);
        busy    <= 1'b1;
      end else if (busy) begin
        rem   <= take ? diff[RESULT_WIDTH:0] : rem_shift;
        quo   <= {quo[RESULT_WIDTH-2:0], take};
        count <= count - 1'b1;
        if (count == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule : bcu_div

FILE: hw/rtl/binomial_coefficient_unit.sv
// Binomial coefficient unit top level: sequencer around the shared multiplier
// and the iterative divider. Depends on bcu_pkg, bcu_in_if, bcu_out_if, bcu_mul, bcu_div.
`timescale 1ns / 1ps
//
//  channel | dir | handshake     | item
//  --------+-----+---------------+------------------------------------
//  in_ch   | in  | valid / ready | n_value, k_value (ARG_WIDTH each)
//  out_ch  | out | valid / ready | coefficient (RESULT_WIDTH), overflow
//
//  k = 0, n = 0 or k > n: the sequencer goes straight to ST_DONE once the item is taken.
//  Otherwise up to k multiplier passes for the falling product, k-1 for k!,
//  then the divider at one quotient bit a cycle; ST_DONE loads the result
//  into the output register once that register is free.
//  in_ch.ready is high only when the sequencer is idle; a finished result
//  waits in the output register, so the next item may be taken meanwhile.
//  Synchronous reset clears the sequencer and the output valid.

module binomial_coefficient_unit
  import bcu_pkg::*;
#(
  parameter int ARG_WIDTH    = 6,
  parameter int RESULT_WIDTH = 64
) (
  input logic      clk,
  input logic      rst,
  bcu_in_if.sink   in_ch,
  bcu_out_if.source out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_FACT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  state_t                  state;
  logic [ARG_WIDTH-1:0]    k_reg;
  logic [ARG_WIDTH-1:0]    factor;
  logic [ARG_WIDTH-1:0]    remaining;
  logic [ARG_WIDTH-1:0]    fidx;
  logic [RESULT_WIDTH-1:0] prod;
  logic [RESULT_WIDTH-1:0] fact;
  logic [RESULT_WIDTH-1:0] res_value;
  logic                    res_ovf;
  logic                    out_valid;
  logic [RESULT_WIDTH-1:0] out_coef;
  logic                    out_ovf;

  logic [RESULT_WIDTH-1:0] mul_acc;
  logic [ARG_WIDTH-1:0]    mul_factor;
  logic [RESULT_WIDTH-1:0] mul_product;
  logic                    mul_too_wide;
  logic                    div_start;
  bcu_div_status_t         div_status;
  logic [RESULT_WIDTH-1:0] div_quotient;
  logic                    in_take;

  // Multiplier operands: falling product first, then k!
  assign mul_acc    = (state == ST_PROD) ? prod : fact;
  assign mul_factor = (state == ST_PROD) ? factor : fidx;
  assign div_start  = (state == ST_DIV_GO);
  assign in_take    = in_ch.valid && (state == ST_IDLE);

  bcu_mul #(
    .ARG_WIDTH   (ARG_WIDTH),
    .RESULT_WIDTH(RESULT_WIDTH)
  ) u_mul (
    .acc     (mul_acc),
    .factor  (mul_factor),
    .product (mul_product),
    .too_wide(mul_too_wide)
  );

  bcu_div #(
    .RESULT_WIDTH(RESULT_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod),
    .divisor (fact),
    .status  (div_status),
    .quotient(div_quotient)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result taken; ST_DONE reloads the register itself
      if (out_valid && out_ch.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            k_reg     <= in_ch.k_value;
            factor    <= in_ch.n_value;
            remaining <= in_ch.k_value;
            prod      <= RESULT_WIDTH'(1);
            fact      <= RESULT_WIDTH'(1);
            fidx      <= ARG_WIDTH'(2);
            res_ovf   <= 1'b0;
            if (in_ch.k_value == '0) begin
              res_value <= RESULT_WIDTH'(1);
              state     <= ST_DONE;
            end else if (in_ch.n_value == '0 || in_ch.k_value > in_ch.n_value) begin
              res_value <= '0;
              state     <= ST_DONE;
            end else begin
              state <= ST_PROD;
            end
          end
        end
        ST_PROD: begin
          if (mul_too_wide) begin
            res_value <= '0;
            res_ovf   <= 1'b1;
            state     <= ST_DONE;
          end else begin
            prod      <= mul_product;
            factor    <= factor - 1'b1;
            remaining <= remaining - 1'b1;
            if (remaining == ARG_WIDTH'(1)) begin
              state <= (k_reg == ARG_WIDTH'(1)) ? ST_DIV_GO : ST_FACT;
            end
          end
        end
        ST_FACT: begin
          fact <= mul_product;
          fidx <= fidx + 1'b1;
          if (fidx == k_reg) begin
            state <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_status.done) begin
            res_value <= div_quotient;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_coef  <= res_value;
            out_ovf   <= res_ovf;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready        = (state == ST_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.coefficient = out_coef;
  assign out_ch.overflow    = out_ovf;

endmodule : binomial_coefficient_unit

FILE: tb/sv/binomial_coefficient_unit_test.sv
// Testbench for the binomial coefficient unit: directed table, then random items in phases.
// Depends on bcu_pkg, bcu_in_if, bcu_out_if and binomial_coefficient_unit.
`timescale 1ns / 1ps

module binomial_coefficient_unit_test;
  import bcu_pkg::*;

  localparam int ARG_WIDTH      = 6;
  localparam int RESULT_WIDTH   = 64;
  localparam int N_DIRECTED     = 21;
  localparam int PHASE_ITEMS    = 400;
  localparam int N_PHASES       = 4;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 150;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  typedef logic [ARG_WIDTH-1:0]    arg_t;
  typedef logic [RESULT_WIDTH-1:0] coef_t;

  // One expected result, with its arguments kept for messages
  typedef struct {
    arg_t  n;
    arg_t  k;
    coef_t coefficient;
    logic  overflow;
  } choose_result_t;

  // Directed row: typed rows carry their own answer, the rest go to the predictor
  typedef struct {
    arg_t  n;
    arg_t  k;
    bit    typed;
    coef_t coefficient;
    logic  overflow;
  } choose_row_t;

  logic clk;
  logic rst;

  bcu_in_if  #(.ARG_WIDTH(ARG_WIDTH))       in_ch ();
  bcu_out_if #(.RESULT_WIDTH(RESULT_WIDTH)) out_ch ();

  binomial_coefficient_unit #(
    .ARG_WIDTH   (ARG_WIDTH),
    .RESULT_WIDTH(RESULT_WIDTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  choose_result_t pending_choices[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int overflow_seen  = 0;
  int trivial_seen   = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  choose_row_t directed_rows [0:N_DIRECTED-1] = '{
    // k zero, with n zero and n at its top
    '{6'd0,  6'd0,  1'b1, 64'd1,    1'b0},
    '{6'd63, 6'd0,  1'b1, 64'd1,    1'b0},
    // n zero
    '{6'd0,  6'd1,  1'b1, 64'd0,    1'b0},
    '{6'd0,  6'd63, 1'b1, 64'd0,    1'b0},
    // k above n, then small ordinary cases
    '{6'd5,  6'd6,  1'b1, 64'd0,    1'b0},
    '{6'd62, 6'd63, 1'b1, 64'd0,    1'b0},
    '{6'd1,  6'd1,  1'b1, 64'd1,    1'b0},
    '{6'd63, 6'd1,  1'b1, 64'd63,   1'b0},
    '{6'd63, 6'd2,  1'b1, 64'd1953, 1'b0},
    '{6'd10, 6'd5,  1'b1, 64'd252,  1'b0},
    // falling product too wide, and the widest that still fits
    '{6'd63, 6'd63, 1'b1, 64'd0,    1'b1},
    '{6'd63, 6'd62, 1'b1, 64'd0,    1'b1},
    '{6'd21, 6'd21, 1'b1, 64'd0,    1'b1},
    '{6'd20, 6'd20, 1'b1, 64'd1,    1'b0},
    // around the overflow boundary plus two small cases, left to the predictor
    '{6'd42, 6'd21, 1'b0, 64'd0,    1'b0},
    '{6'd21, 6'd10, 1'b0, 64'd0,    1'b0},
    '{6'd63, 6'd10, 1'b0, 64'd0,    1'b0},
    '{6'd63, 6'd11, 1'b0, 64'd0,    1'b0},
    '{6'd63, 6'd12, 1'b0, 64'd0,    1'b0},
    '{6'd33, 6'd17, 1'b0, 64'd0,    1'b0},
    '{6'd40, 6'd3,  1'b0, 64'd0,    1'b0}
  };

  // n choose k with the overflow rule on the falling product
  function automatic choose_result_t choose_coefficient(input arg_t n, input arg_t k);
    choose_result_t   res;
    longint unsigned  falling;
    longint unsigned  kfact;
    longint unsigned  factor;
    bit               too_wide;
    int               i;
    res.n           = n;
    res.k           = k;
    res.coefficient = '0;
    res.overflow    = 1'b0;
    falling         = 1;
    kfact           = 1;
    too_wide        = 1'b0;
    if (k == 0) begin
      res.coefficient = 64'd1;
      return res;
    end
    if (n == 0 || k > n) begin
      return res;
    end
    for (i = 0; i < int'(k); i++) begin
      factor = longint'(n) - longint'(i);
      if (falling > 64'hFFFF_FFFF_FFFF_FFFF / factor) begin
        too_wide = 1'b1;
        break;
      end
      falling = falling * factor;
    end
    if (too_wide) begin
      res.overflow = 1'b1;
      return res;
    end
    for (i = 2; i <= int'(k); i++) begin
      kfact = kfact * longint'(i);
    end
    res.coefficient = falling / kfact;
    return res;
  endfunction

  // Offer one item at the falling edge, hold it until taken, log the expectation
  task automatic offer_pair(input arg_t n, input arg_t k, input bit typed,
                            input coef_t coefficient, input logic overflow);
    choose_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.n_value <= n;
    in_ch.k_value <= k;
    do @(posedge clk); while (!in_ch.ready);
    want = choose_coefficient(n, k);
    if (typed) begin
      want.coefficient = coefficient;
      want.overflow    = overflow;
    end
    pending_choices.push_back(want);
    items_sent++;
    @(negedge clk);
  endtask

  // Random arguments: mostly in-range k, with special cases and noise mixed in
  task automatic pick_arguments(output arg_t n, output arg_t k);
    int sel;
    int ni;
    int ki;
    int top;
    sel = $urandom_range(99);
    ni  = $urandom_range(63);
    if (sel < 5) begin
      ki = 0;
    end else if (sel < 12) begin
      if (ni == 63) ni = $urandom_range(62);
      ki = $urandom_range(63, ni + 1);
    end else if (sel < 22) begin
      ki = $urandom_range(63);
    end else if (sel < 32) begin
      // k close to n: small coefficient behind a wide falling product
      if (ni == 0) ni = 1;
      ki = ni - $urandom_range((ni < 4) ? ni - 1 : 3);
    end else begin
      if (sel < 70) ni = $urandom_range(40, 1);
      else if (ni == 0) ni = 1;
      top = (ni < 12) ? ni : 12;
      ki  = $urandom_range(top, 1);
    end
    n = arg_t'(ni);
    k = arg_t'(ki);
  endtask

  task automatic wait_results_drained();
    while (pending_choices.size() != 0) @(negedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, plus a long counted hold on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        out_ch.ready <= 1'b0;
        for (int hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) @(negedge clk);
        holds_served = hold_requests;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result check and watchdog
  always @(posedge clk) begin
    choose_result_t want;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.overflow === 1'b1) overflow_seen++;
        if (pending_choices.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: coefficient=%0d overflow=%0b",
                     out_ch.coefficient, out_ch.overflow);
        end else begin
          want = pending_choices.pop_front();
          if (want.coefficient !== out_ch.coefficient || want.overflow !== out_ch.overflow)
          begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch n=%0d k=%0d: expected %0d/%0b, got %0d/%0b",
                       want.n, want.k, want.coefficient, want.overflow,
                       out_ch.coefficient, out_ch.overflow);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", quiet_cycles);
        $display("** binomial_coefficient_unit: FAILED **");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int   send_pct [N_PHASES] = '{0, 86, 0, 30};
    int   recv_pct [N_PHASES] = '{0, 0, 86, 30};
    arg_t n;
    arg_t k;
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.n_value <= '0;
    in_ch.k_value <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table, no idling
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].k == 0 || directed_rows[r].n == 0 ||
          directed_rows[r].k > directed_rows[r].n)
        trivial_seen++;
      offer_pair(directed_rows[r].n, directed_rows[r].k, directed_rows[r].typed,
                 directed_rows[r].coefficient, directed_rows[r].overflow);
    end

    // Random phases; the sender waits for every result between phases
    for (int ph = 0; ph < N_PHASES; ph++) begin
      in_ch.valid <= 1'b0;
      wait_results_drained();
      @(negedge clk);
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      // long receiver hold while the sender keeps offering
      if (ph == 0 || ph == 2) hold_requests++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick_arguments(n, k);
        if (k == 0 || n == 0 || k > n) trivial_seen++;
        offer_pair(n, k, 1'b0, '0, 1'b0);
      end
    end

    in_ch.valid    <= 1'b0;
    recv_stall_pct = 0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d items (%0d special-case arguments), %0d results checked,",
             items_sent, trivial_seen, results_seen);
    $display("%0d with overflow, over four idling phases and two long receiver holds",
             overflow_seen);
    if (pending_choices.size() != 0)
      $display("%0d expected results never arrived", pending_choices.size());
    if (mismatches == 0 && pending_choices.size() == 0) begin
      $display("** binomial_coefficient_unit: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** binomial_coefficient_unit: FAILED **");
    end
    $finish;
  end

endmodule : binomial_coefficient_unit_test

FILE: filelist.f
hw/rtl/bcu_pkg.sv
hw/rtl/bcu_in_if.sv
hw/rtl/bcu_out_if.sv
hw/rtl/bcu_mul.sv
hw/rtl/bcu_div.sv
hw/rtl/binomial_coefficient_unit.sv
tb/sv/binomial_coefficient_unit_test.sv
